// File: design/biq_pkg.sv
// Shared types and constants for the multichannel biquad filter.
// No dependencies; every other file of the block imports it.
package biq_pkg;

  // Default parameter values.
  localparam int DefChannels     = 8;
  localparam int DefSampleWidth  = 24;
  localparam int DefCoefFracBits = 20;

  // Fixed field widths.
  localparam int ChW    = 3;   // channel index
  localparam int CoefW  = 24;  // Q4.20 coefficient
  localparam int RegIdxW = 3;  // configuration register index
  localparam int NumRegs = 5;
  localparam int NumStages = 3;

  // Coefficient register indexes.
  typedef enum logic [RegIdxW-1:0] {
    RegFeed0 = 3'd0,
    RegFeed1 = 3'd1,
    RegFeed2 = 3'd2,
    RegBack1 = 3'd3,
    RegBack2 = 3'd4
  } biq_reg_e;

  // Coefficient values after reset.
  localparam logic signed [CoefW-1:0] Feed0Rst = 24'sd4106;
  localparam logic signed [CoefW-1:0] Feed1Rst = 24'sd8213;
  localparam logic signed [CoefW-1:0] Feed2Rst = 24'sd4106;
  localparam logic signed [CoefW-1:0] Back1Rst = -24'sd1903498;
  localparam logic signed [CoefW-1:0] Back2Rst = 24'sd871353;

  typedef struct packed {
    logic signed [CoefW-1:0] feed0;
    logic signed [CoefW-1:0] feed1;
    logic signed [CoefW-1:0] feed2;
    logic signed [CoefW-1:0] back1;
    logic signed [CoefW-1:0] back2;
  } biq_coef_t;

  // Occupancy of one arithmetic stage, used for the same-channel interlock.
  typedef struct packed {
    logic           v;
    logic           rng;
    logic [ChW-1:0] ch;
  } biq_stat_t;

endpackage

// File: design/biq_hist_mem.sv
// Per-channel history memory: one entry holds x1, x2, y1, y2 of a channel.
// Synchronous, registered read; one write port, valid bit per entry.
// Depends on biq_pkg.
module biq_hist_mem import biq_pkg::*; #(
  parameter int CHANNELS     = DefChannels,
  parameter int SAMPLE_WIDTH = DefSampleWidth,
  parameter int Aw           = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      clr_i,
  input  logic                      rd_en_i,
  input  logic [Aw-1:0]             rd_addr_i,
  output logic [4*SAMPLE_WIDTH-1:0] rd_data_o,
  input  logic                      we_i,
  input  logic [Aw-1:0]             wr_addr_i,
  input  logic [4*SAMPLE_WIDTH-1:0] wr_data_i
);

  localparam int EntW = 4 * SAMPLE_WIDTH;

  logic [EntW-1:0]     mem_q [CHANNELS];
  logic [EntW-1:0]     rd_data_q;
  logic                rd_vld_q;
  logic [CHANNELS-1:0] vld_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  // Entries never written since the last clear read as zero history.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (clr_i) begin
        vld_q <= '0;
      end else if (we_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= vld_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_vld_q ? rd_data_q : '0;

endmodule

// File: design/biq_mac.sv
// Three-stage multiply-accumulate pipeline: tag and history, products, sum;
// round and saturate follow the sum combinationally. Takes history from
// biq_hist_mem and returns the write-back entry. Depends on biq_pkg.
module biq_mac import biq_pkg::*; #(
  parameter int SAMPLE_WIDTH   = DefSampleWidth,
  parameter int COEF_FRAC_BITS = DefCoefFracBits
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  biq_coef_t                     coef_i,
  input  logic                          in_valid_i,
  input  logic [ChW-1:0]                in_ch_i,
  input  logic                          in_last_i,
  input  logic                          in_rng_i,
  input  logic [SAMPLE_WIDTH-1:0]       in_x_i,
  output logic                          in_free_o,
  input  logic [4*SAMPLE_WIDTH-1:0]     hist_i,
  input  logic                          adv_i,
  output biq_stat_t [NumStages-1:0]     stat_o,
  output logic                          res_valid_o,
  output logic [ChW-1:0]                res_ch_o,
  output logic                          res_last_o,
  output logic                          res_rng_o,
  output logic [SAMPLE_WIDTH-1:0]       res_y_o,
  output logic [4*SAMPLE_WIDTH-1:0]     res_entry_o
);

  localparam int Sw  = SAMPLE_WIDTH;
  localparam int F   = COEF_FRAC_BITS;
  localparam int Pw  = Sw + CoefW;
  localparam int Acw = (CoefW > F) ? Sw + CoefW + 3 : Sw + F + 4;
  localparam int Rw  = Acw - F;
  localparam logic signed [Acw-1:0] Half = {{(Acw-F){1'b0}}, 1'b1, {(F-1){1'b0}}};
  localparam logic signed [Sw-1:0]  YMax = {1'b0, {(Sw-1){1'b1}}};
  localparam logic signed [Sw-1:0]  YMin = {1'b1, {(Sw-1){1'b0}}};

  // Stage 1: item tag; history arrives from memory in this stage.
  logic           s1_v_q, s1_last_q, s1_rng_q;
  logic [ChW-1:0] s1_ch_q;
  logic [Sw-1:0]  s1_x_q;
  // Stage 2: products.
  logic           s2_v_q, s2_last_q, s2_rng_q;
  logic [ChW-1:0] s2_ch_q;
  logic [Sw-1:0]  s2_x_q, s2_x1_q, s2_y1_q;
  logic signed [Pw-1:0] p_d [5];
  logic signed [Pw-1:0] p_q [5];
  // Stage 3: sum.
  logic           s3_v_q, s3_last_q, s3_rng_q;
  logic [ChW-1:0] s3_ch_q;
  logic [Sw-1:0]  s3_x_q, s3_x1_q, s3_y1_q;
  logic signed [Acw-1:0] acc_d, acc_q;

  logic s1_en, s2_en, s3_en;
  logic signed [Acw-1:0] rnd;
  logic signed [Rw-1:0]  r;
  logic [Sw-1:0] y_sat;

  assign s3_en     = !s3_v_q || adv_i;
  assign s2_en     = !s2_v_q || s3_en;
  assign s1_en     = !s1_v_q || s2_en;
  assign in_free_o = s1_en;

  always_comb begin
    p_d[0] = Pw'(signed'(s1_x_q))                  * Pw'(coef_i.feed0);
    p_d[1] = Pw'(signed'(hist_i[Sw-1:0]))          * Pw'(coef_i.feed1);
    p_d[2] = Pw'(signed'(hist_i[2*Sw-1:Sw]))       * Pw'(coef_i.feed2);
    p_d[3] = Pw'(signed'(hist_i[3*Sw-1:2*Sw]))     * Pw'(coef_i.back1);
    p_d[4] = Pw'(signed'(hist_i[4*Sw-1:3*Sw]))     * Pw'(coef_i.back2);
  end

  assign acc_d = Acw'(p_q[0]) + Acw'(p_q[1]) + Acw'(p_q[2])
               - Acw'(p_q[3]) - Acw'(p_q[4]);

  // Round half up, then clamp to the sample range.
  assign rnd = acc_q + Half;
  assign r   = rnd[Acw-1:F];

  always_comb begin
    if (r > Rw'(YMax)) begin
      y_sat = YMax;
    end else if (r < Rw'(YMin)) begin
      y_sat = YMin;
    end else begin
      y_sat = r[Sw-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
    end else begin
      if (s1_en) begin
        s1_v_q <= in_valid_i;
      end
      if (s2_en) begin
        s2_v_q <= s1_v_q;
      end
      if (s3_en) begin
        s3_v_q <= s2_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && s1_en) begin
      s1_ch_q   <= in_ch_i;
      s1_last_q <= in_last_i;
      s1_rng_q  <= in_rng_i;
      s1_x_q    <= in_x_i;
    end
    if (s1_v_q && s2_en) begin
      s2_ch_q   <= s1_ch_q;
      s2_last_q <= s1_last_q;
      s2_rng_q  <= s1_rng_q;
      s2_x_q    <= s1_x_q;
      s2_x1_q   <= hist_i[Sw-1:0];
      s2_y1_q   <= hist_i[3*Sw-1:2*Sw];
      for (int i = 0; i < 5; i++) begin
        p_q[i] <= p_d[i];
      end
    end
    if (s2_v_q && s3_en) begin
      s3_ch_q   <= s2_ch_q;
      s3_last_q <= s2_last_q;
      s3_rng_q  <= s2_rng_q;
      s3_x_q    <= s2_x_q;
      s3_x1_q   <= s2_x1_q;
      s3_y1_q   <= s2_y1_q;
      acc_q     <= acc_d;
    end
  end

  assign stat_o[0] = '{v: s1_v_q, rng: s1_rng_q, ch: s1_ch_q};
  assign stat_o[1] = '{v: s2_v_q, rng: s2_rng_q, ch: s2_ch_q};
  assign stat_o[2] = '{v: s3_v_q, rng: s3_rng_q, ch: s3_ch_q};

  assign res_valid_o = s3_v_q;
  assign res_ch_o    = s3_ch_q;
  assign res_last_o  = s3_last_q;
  assign res_rng_o   = s3_rng_q;
  // Pass the sample through unchanged for a channel beyond the configured count.
  assign res_y_o     = s3_rng_q ? y_sat : s3_x_q;
  // Entry layout from the low end: x1, x2, y1, y2.
  assign res_entry_o = {s3_y1_q, y_sat, s3_x1_q, s3_x_q};

endmodule

// File: design/multichannel_biquad_filter_top.sv
// Top level of the multichannel biquad filter (direct form I).
// Holds the coefficient registers, the output register and the interlock;
// instantiates biq_hist_mem and biq_mac. Depends on biq_pkg.
//
//  channel   direction  tdata / data             tuser / index    tlast
//  s_axis    in         sample_in                channel_index    end_of_block
//  m_axis    out        sample_out               channel_out      end_of_block_out
//  cfg       in         cfg_data_i (coefficient) cfg_addr_i       -
//
// At acceptance the item is registered and its history read; the products, the
// sum and the rounded, saturated result are then registered in turn, the last in
// the output register. Items of different channels enter one per cycle while
// the stages have room. A channel's next item waits until its previous one has
// been written back to the history memory, so one channel alone takes no new
// item before its last one is through. Reset clears the valid bits of the
// history memory at once, so the block takes items from the first cycle after
// reset; a coefficient write clears them likewise. The output register parts
// the two sides: a held result stalls only the stages behind it that are full.
module multichannel_biquad_filter_top import biq_pkg::*; #(
  parameter int CHANNELS       = DefChannels,
  parameter int SAMPLE_WIDTH   = DefSampleWidth,
  parameter int COEF_FRAC_BITS = DefCoefFracBits,
  parameter int TDW            = ((SAMPLE_WIDTH + 7) / 8) * 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // Input stream
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [TDW-1:0]     s_axis_tdata,   // [SAMPLE_WIDTH-1:0] sample_in
  input  logic [ChW-1:0]     s_axis_tuser,   // [2:0] channel_index
  input  logic               s_axis_tlast,   // end_of_block
  // Output stream
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [TDW-1:0]     m_axis_tdata,   // [SAMPLE_WIDTH-1:0] sample_out
  output logic [ChW-1:0]     m_axis_tuser,   // [2:0] channel_out
  output logic               m_axis_tlast,   // end_of_block_out
  // Coefficient writes
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [RegIdxW-1:0] cfg_addr_i,
  input  logic [CoefW-1:0]   cfg_data_i
);

  localparam int Sw = SAMPLE_WIDTH;
  localparam int Aw = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  biq_coef_t coef_q;
  logic      clr;
  logic      cfg_we;

  logic [Sw-1:0]          in_x;
  logic                   in_rng;
  logic [Aw+ChW-1:0]      in_addr_ext;
  logic [Aw-1:0]          in_addr;
  logic                   hazard;
  logic                   in_free;
  logic                   accept;

  biq_stat_t [NumStages-1:0] stat;
  logic [4*Sw-1:0] hist;
  logic            res_valid, res_last, res_rng;
  logic [ChW-1:0]  res_ch;
  logic [Sw-1:0]   res_y;
  logic [4*Sw-1:0] res_entry;
  logic [Aw+ChW-1:0] wr_addr_ext;
  logic            out_free, res_move;

  logic            out_v_q;
  logic [Sw-1:0]   out_y_q;
  logic [ChW-1:0]  out_ch_q;
  logic            out_last_q;

  // Coefficient registers; a write to any listed register clears all history.
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  always_comb begin
    clr = 1'b0;
    if (cfg_we) begin
      case (cfg_addr_i)
        RegFeed0, RegFeed1, RegFeed2, RegBack1, RegBack2: clr = 1'b1;
        default: clr = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q <= '{feed0: Feed0Rst, feed1: Feed1Rst, feed2: Feed2Rst,
                  back1: Back1Rst, back2: Back2Rst};
    end else if (cfg_we) begin
      case (cfg_addr_i)
        RegFeed0: coef_q.feed0 <= cfg_data_i;
        RegFeed1: coef_q.feed1 <= cfg_data_i;
        RegFeed2: coef_q.feed2 <= cfg_data_i;
        RegBack1: coef_q.back1 <= cfg_data_i;
        RegBack2: coef_q.back2 <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Input side: channels beyond the configured count bypass the history.
  assign in_x        = s_axis_tdata[Sw-1:0];
  assign in_rng      = int'(s_axis_tuser) < CHANNELS;
  assign in_addr_ext = (Aw+ChW)'(s_axis_tuser);
  assign in_addr     = in_addr_ext[Aw-1:0];

  // Hold an item whose channel still has an item in flight before write-back.
  always_comb begin
    hazard = 1'b0;
    for (int i = 0; i < NumStages; i++) begin
      if (stat[i].v && stat[i].rng && in_rng && stat[i].ch == s_axis_tuser) begin
        hazard = 1'b1;
      end
    end
  end

  assign s_axis_tready = in_free && !hazard;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Advance the last stage into the output register and write history back.
  assign out_free    = !out_v_q || m_axis_tready;
  assign res_move    = res_valid && out_free;
  assign wr_addr_ext = (Aw+ChW)'(res_ch);

  biq_hist_mem #(
    .CHANNELS    (CHANNELS),
    .SAMPLE_WIDTH(SAMPLE_WIDTH),
    .Aw          (Aw)
  ) u_hist_mem (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .clr_i    (clr),
    .rd_en_i  (accept && in_rng),
    .rd_addr_i(in_addr),
    .rd_data_o(hist),
    .we_i     (res_move && res_rng),
    .wr_addr_i(wr_addr_ext[Aw-1:0]),
    .wr_data_i(res_entry)
  );

  biq_mac #(
    .SAMPLE_WIDTH  (SAMPLE_WIDTH),
    .COEF_FRAC_BITS(COEF_FRAC_BITS)
  ) u_mac (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .coef_i     (coef_q),
    .in_valid_i (accept),
    .in_ch_i    (s_axis_tuser),
    .in_last_i  (s_axis_tlast),
    .in_rng_i   (in_rng),
    .in_x_i     (in_x),
    .in_free_o  (in_free),
    .hist_i     (hist),
    .adv_i      (out_free),
    .stat_o     (stat),
    .res_valid_o(res_valid),
    .res_ch_o   (res_ch),
    .res_last_o (res_last),
    .res_rng_o  (res_rng),
    .res_y_o    (res_y),
    .res_entry_o(res_entry)
  );

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (out_free) begin
      out_v_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_move) begin
      out_y_q    <= res_y;
      out_ch_q   <= res_ch;
      out_last_q <= res_last;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = TDW'(out_y_q);
  assign m_axis_tuser  = out_ch_q;
  assign m_axis_tlast  = out_last_q;

endmodule

// File: bench/testbench.sv
// Self-checking bench for multichannel_biquad_filter_top: drives sample and
// coefficient streams, predicts every filtered sample and compares field by field.
// Depends on biq_pkg and the filter RTL only.
module testbench;
  import biq_pkg::*;

  localparam int Channels      = DefChannels;
  localparam int SampleW       = DefSampleWidth;
  localparam int CoefFracBits  = DefCoefFracBits;
  localparam int TdW           = ((SampleW + 7) / 8) * 8;
  localparam int NumPhases     = 10;
  localparam int ItemsPerPhase = 150;
  localparam int HoldOffCycles = 300;
  localparam int SettleCycles  = 8;
  localparam int CycleLimit    = 1_000_000;
  localparam int MaxReportLines = 200;

  localparam logic signed [SampleW-1:0] SampleMax = {1'b0, {(SampleW-1){1'b1}}};
  localparam logic signed [SampleW-1:0] SampleMin = {1'b1, {(SampleW-1){1'b0}}};
  localparam logic signed [CoefW-1:0]   CoefMax   = {1'b0, {(CoefW-1){1'b1}}};
  localparam logic signed [CoefW-1:0]   CoefMin   = {1'b1, {(CoefW-1){1'b0}}};
  localparam logic signed [CoefW-1:0]   CoefZero  = '0;
  localparam logic signed [CoefW-1:0]   CoefUnity = CoefW'(longint'(1) << CoefFracBits);
  localparam logic signed [CoefW-1:0]   CoefHalf  = CoefW'(longint'(1) << (CoefFracBits - 1));

  typedef enum int {CoefReset, CoefFull, CoefSingle, CoefExtreme, CoefGentle} coef_mix_e;
  typedef enum int {ChanRoundRobin, ChanRandom, ChanSingle, ChanPair} chan_mix_e;

  typedef struct {
    logic [SampleW-1:0] sample;
    logic [ChW-1:0]     ch;
    logic               last;
  } filtered_t;

  // Scoreboard: own copy of coefficients and per-channel history, plus the
  // filtered samples still owed by the block, oldest first.
  class biq_scoreboard;
    logic signed [CoefW-1:0]   coef [NumRegs];
    logic signed [SampleW-1:0] x_d1 [Channels];
    logic signed [SampleW-1:0] x_d2 [Channels];
    logic signed [SampleW-1:0] y_d1 [Channels];
    logic signed [SampleW-1:0] y_d2 [Channels];
    filtered_t                 filtered_due [$];
    int                        errors;

    function void clear_history();
      foreach (x_d1[c]) begin
        x_d1[c] = '0;
        x_d2[c] = '0;
        y_d1[c] = '0;
        y_d2[c] = '0;
      end
    endfunction

    function void restore();
      coef[RegFeed0] = Feed0Rst;
      coef[RegFeed1] = Feed1Rst;
      coef[RegFeed2] = Feed2Rst;
      coef[RegBack1] = Back1Rst;
      coef[RegBack2] = Back2Rst;
      clear_history();
    endfunction

    // Writes past the register list are ignored and keep the history.
    function void write_reg(logic [RegIdxW-1:0] idx, logic [CoefW-1:0] value);
      if (idx < NumRegs) begin
        coef[idx] = value;
        clear_history();
      end
    endfunction

    function void note_sample(logic signed [SampleW-1:0] x, logic [ChW-1:0] ch, logic last);
      longint    acc;
      longint    hi;
      longint    lo;
      filtered_t r;
      hi = (longint'(1) << (SampleW - 1)) - 1;
      lo = -hi - 1;
      r.sample = x;
      r.ch     = ch;
      r.last   = last;
      if (ch < Channels) begin
        acc = longint'(coef[RegFeed0]) * longint'(x)
            + longint'(coef[RegFeed1]) * longint'(x_d1[ch])
            + longint'(coef[RegFeed2]) * longint'(x_d2[ch])
            - longint'(coef[RegBack1]) * longint'(y_d1[ch])
            - longint'(coef[RegBack2]) * longint'(y_d2[ch]);
        // add half an LSB, then floor
        acc = (acc + (longint'(1) << (CoefFracBits - 1))) >>> CoefFracBits;
        if (acc > hi) acc = hi;
        else if (acc < lo) acc = lo;
        r.sample = acc[SampleW-1:0];
        x_d2[ch] = x_d1[ch];
        x_d1[ch] = x;
        y_d2[ch] = y_d1[ch];
        y_d1[ch] = r.sample;
      end
      filtered_due.push_back(r);
    endfunction

    task report(string msg);
      errors++;
      if (errors <= MaxReportLines) $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task check_output(logic [SampleW-1:0] s, logic [ChW-1:0] ch, logic last);
      filtered_t w;
      if (filtered_due.size() == 0) begin
        report($sformatf("result with nothing due: sample %0d channel %0d",
                         $signed(s), ch));
        return;
      end
      w = filtered_due.pop_front();
      if (s !== w.sample)
        report($sformatf("sample_out %0d, expected %0d (channel %0d)",
                         $signed(s), $signed(w.sample), w.ch));
      if (ch !== w.ch)
        report($sformatf("channel_out %0d, expected %0d", ch, w.ch));
      if (last !== w.last)
        report($sformatf("end_of_block_out %0b, expected %0b (channel %0d)",
                         last, w.last, w.ch));
    endtask
  endclass

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [TdW-1:0]      s_axis_tdata  = '0;
  logic [ChW-1:0]      s_axis_tuser  = '0;
  logic                s_axis_tlast  = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [TdW-1:0]      m_axis_tdata;
  logic [ChW-1:0]      m_axis_tuser;
  logic                m_axis_tlast;
  logic                cfg_valid_i   = 1'b0;
  logic                cfg_ready_o;
  logic [RegIdxW-1:0]  cfg_addr_i    = '0;
  logic [CoefW-1:0]    cfg_data_i    = '0;

  biq_scoreboard sb;
  bit            tx_steady;
  bit            rx_steady;
  bit            hold_off_req;
  int            cycle_count;

  multichannel_biquad_filter_top #(
    .CHANNELS       (Channels),
    .SAMPLE_WIDTH   (SampleW),
    .COEF_FRAC_BITS (CoefFracBits)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // Mostly short idles, now and then a long one.
  function automatic int idle_len();
    return ($urandom_range(0, 9) == 0) ? int'($urandom_range(8, 40))
                                       : int'($urandom_range(1, 3));
  endfunction

  function automatic logic [CoefW-1:0] coef_value(coef_mix_e mix);
    case (mix)
      CoefExtreme: begin
        case ($urandom_range(0, 3))
          0: return CoefMax;
          1: return CoefMin;
          2: return CoefZero;
          default: return CoefUnity;
        endcase
      end
      CoefGentle: return CoefW'(int'($urandom_range(0, 1 << CoefFracBits))
                                - (1 << (CoefFracBits - 1)));
      default: return CoefW'($urandom());
    endcase
  endfunction

  task automatic send_sample(logic signed [SampleW-1:0] x, logic [ChW-1:0] ch,
                             logic last);
    logic [TdW-1:0] word;
    int             gap;
    word = '0;
    word[SampleW-1:0] = x;
    gap = (tx_steady || $urandom_range(0, 99) >= 30) ? 0 : idle_len();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= word;
    s_axis_tuser  <= ch;
    s_axis_tlast  <= last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_sample(x, ch, last);
  endtask

  task automatic end_stream();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
  endtask

  // Hold until every owed result is back, then let the pipeline settle.
  task automatic wait_idle();
    while (sb.filtered_due.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [RegIdxW-1:0] idx, logic [CoefW-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.write_reg(idx, value);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic load_coefs(biq_coef_t c);
    write_reg(RegFeed0, c.feed0);
    write_reg(RegFeed1, c.feed1);
    write_reg(RegFeed2, c.feed2);
    write_reg(RegBack1, c.back1);
    write_reg(RegBack2, c.back2);
  endtask

  // Output side: random stalls, plus one long hold-off on request.
  initial begin : sink_ready
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HoldOffCycles) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end else if (!rx_steady && $urandom_range(0, 99) < 25) begin
        m_axis_tready <= 1'b0;
        repeat (idle_len()) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_output(m_axis_tdata[SampleW-1:0], m_axis_tuser, m_axis_tlast);
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("multichannel_biquad_filter_top regression: fail");
      $finish;
    end
  end

  initial begin : stimulus
    biq_coef_t                 coefs;
    coef_mix_e                 mix;
    chan_mix_e                 pattern;
    int                        frame_len;
    int                        r;
    logic [ChW-1:0]            ch_a;
    logic [ChW-1:0]            ch_b;
    logic [ChW-1:0]            ch;
    logic signed [SampleW-1:0] x;
    logic                      eob;
    sb = new();
    sb.restore();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset coefficients: extremes on every channel, then a second sample on
    // a channel to pick up its history.
    send_sample(0, 0, 1'b0);
    send_sample(SampleMax, 1, 1'b0);
    send_sample(SampleMin, 2, 1'b0);
    send_sample(SampleMax, 3, 1'b1);
    send_sample(-1, 4, 1'b0);
    send_sample(1, 5, 1'b0);
    send_sample(SampleMax, 6, 1'b0);
    send_sample(SampleMin, 7, 1'b1);
    send_sample(SampleMax, 1, 1'b0);
    end_stream();
    wait_idle();

    // A write past the register list must leave history alone.
    write_reg(RegIdxW'(NumRegs), '1);
    send_sample(SampleMin, 1, 1'b0);
    send_sample(0, 6, 1'b1);
    end_stream();
    wait_idle();

    // Largest gains: drive the sum past both saturation limits.
    load_coefs({CoefMax, CoefMax, CoefMax, CoefMin, CoefMax});
    send_sample(SampleMax, 0, 1'b0);
    send_sample(SampleMin, 1, 1'b0);
    send_sample(SampleMax, 0, 1'b0);
    send_sample(SampleMin, 0, 1'b1);
    end_stream();
    wait_idle();

    // Gain of one half: odd samples land exactly on a rounding tie.
    load_coefs({CoefHalf, CoefZero, CoefZero, CoefZero, CoefZero});
    send_sample(1, 2, 1'b0);
    send_sample(-1, 2, 1'b0);
    send_sample(3, 3, 1'b0);
    send_sample(-3, 3, 1'b1);
    end_stream();
    wait_idle();

    for (int p = 0; p < NumPhases; p++) begin
      if (p == 0) mix = CoefReset;
      else if (p == 1) mix = CoefExtreme;
      else if (p == 2) mix = CoefGentle;
      else mix = coef_mix_e'($urandom_range(int'(CoefFull), int'(CoefGentle)));

      case (mix)
        CoefReset:  load_coefs({Feed0Rst, Feed1Rst, Feed2Rst, Back1Rst, Back2Rst});
        CoefSingle: write_reg(RegIdxW'($urandom_range(0, NumRegs - 1)),
                              coef_value(CoefFull));
        default: begin
          coefs.feed0 = coef_value(mix);
          coefs.feed1 = coef_value(mix);
          coefs.feed2 = coef_value(mix);
          coefs.back1 = coef_value(mix);
          coefs.back2 = coef_value(mix);
          load_coefs(coefs);
        end
      endcase

      // Phase two runs flat out against a long output hold-off so the
      // pipeline fills and back-pressures the input.
      tx_steady = (p == 2) || ($urandom_range(0, 3) == 0);
      rx_steady = (p != 2) && ($urandom_range(0, 3) == 0);
      if (p == 2) hold_off_req = 1'b1;

      pattern   = chan_mix_e'($urandom_range(int'(ChanRoundRobin), int'(ChanPair)));
      ch_a      = ChW'($urandom());
      ch_b      = ChW'($urandom());
      frame_len = $urandom_range(1, 16);

      for (int n = 0; n < ItemsPerPhase; n++) begin
        case (pattern)
          ChanRoundRobin: ch = ChW'(n);
          ChanSingle:     ch = ch_a;
          ChanPair:       ch = n[0] ? ch_b : ch_a;
          default:        ch = ChW'($urandom());
        endcase
        r = $urandom_range(0, 99);
        if (r < 8) x = r[0] ? SampleMax : SampleMin;
        else if (r < 40) x = SampleW'(int'($urandom_range(0, 8191)) - 4096);
        else x = SampleW'($urandom());
        // frames of a fixed length, with the odd stray or missing marker
        eob = ((n % frame_len) == frame_len - 1) ^ ($urandom_range(0, 31) == 0);
        send_sample(x, ch, eob);
      end
      end_stream();
      wait_idle();
    end

    if (sb.errors == 0) begin
      $display("multichannel_biquad_filter_top regression: pass");
    end else begin
      $display("multichannel_biquad_filter_top regression: fail");
    end
    $finish;
  end

endmodule
